// ===== rtl/assert_macros.svh =====
// assertion macros shared by the ranger rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: %m");

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: %m");

`endif

// ===== rtl/msr_pkg.sv =====
// shared types and constants of the multiplexed sonar ranger
package msr_pkg;

  // default parameter values
  localparam int NUM_SENSORS_DEF = 8;
  localparam int COUNT_BITS_DEF  = 24;
  localparam int FIFO_DEPTH_DEF  = 8;

  // field widths
  localparam int SENSOR_OUT_W = 3;
  localparam int CM_W         = 10;
  localparam int PHASE_CNT_W  = 28;
  localparam int SETTLE_W     = 24;
  localparam int TRIG_W       = 16;
  localparam int TIMEOUT_W    = 24;
  localparam int TPC_W        = 16;
  localparam int STOP_W       = 10;
  localparam int GAP_W        = 28;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 28;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_TRIG    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_TPC     = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_STOP    = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_GAP     = CFG_IDX_W'(5);

  // register reset values
  localparam logic [SETTLE_W-1:0]  SETTLE_RST  = SETTLE_W'(2400000);
  localparam logic [TRIG_W-1:0]    TRIG_RST    = TRIG_W'(1200);
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = TIMEOUT_W'(2000000);
  localparam logic [TPC_W-1:0]     TPC_RST     = TPC_W'(3495);
  localparam logic [STOP_W-1:0]    STOP_RST    = STOP_W'(50);
  localparam logic [GAP_W-1:0]     GAP_RST     = GAP_W'(30000000);

  // special range codes
  localparam logic [CM_W-1:0] CM_NO_ECHO = CM_W'(999);
  localparam logic [CM_W-1:0] CM_SAT     = CM_W'(998);

  // timing registers seen by the front end
  typedef struct packed {
    logic [SETTLE_W-1:0]  settle;
    logic [TRIG_W-1:0]    trig;
    logic [TIMEOUT_W-1:0] timeout;
    logic [GAP_W-1:0]     gap;
  } msr_front_cfg_t;

  // conversion registers seen by the back end
  typedef struct packed {
    logic [TPC_W-1:0]  tpc;
    logic [STOP_W-1:0] stop;
  } msr_back_cfg_t;

  // per-tick control record passed through the queue
  typedef struct packed {
    logic                    trigger;
    logic [SENSOR_OUT_W-1:0] sensor;
    logic                    done;
    logic                    timeout;
    logic                    scan_end;
  } msr_ctrl_t;

endpackage

// ===== rtl/msr_front.sv =====
// front end: per-tick scan sequencer that classifies each tick
module msr_front import msr_pkg::*; #(
  parameter int NUM_SENSORS = NUM_SENSORS_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  msr_front_cfg_t        cfg_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  echo_level_i,
  input  logic                  full_i,
  output logic                  push_o,
  output msr_ctrl_t             ctrl_o,
  output logic [COUNT_BITS-1:0] len_o
);

  localparam int SENSOR_W = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
  localparam logic [SENSOR_W-1:0] LAST_SENSOR = SENSOR_W'(NUM_SENSORS - 1);

  typedef enum logic [2:0] {
    PH_SETTLE,
    PH_TRIG,
    PH_WAIT1,
    PH_WAIT2,
    PH_GAP
  } phase_e;

  phase_e                   phase_q, phase_d;
  logic [SENSOR_W-1:0]      sensor_q, sensor_d;
  logic [PHASE_CNT_W-1:0]   pcnt_q, pcnt_d;
  logic [COUNT_BITS-1:0]    pulse_q, pulse_d;
  logic                     last_echo_q;
  logic                     echo_edge;
  logic [SENSOR_W+2:0]      sensor_ext;

  // accept whenever the queue has room
  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && in_ready_o;
  assign echo_edge  = echo_level_i != last_echo_q;

  // next state and record for this tick
  always_comb begin
    phase_d  = phase_q;
    sensor_d = sensor_q;
    pcnt_d   = pcnt_q;
    pulse_d  = pulse_q;
    ctrl_o   = '0;

    if (phase_d == PH_GAP && pcnt_d >= PHASE_CNT_W'(cfg_i.gap)) begin
      phase_d  = PH_SETTLE;
      sensor_d = '0;
      pcnt_d   = '0;
    end
    if (phase_d == PH_SETTLE && pcnt_d >= PHASE_CNT_W'(cfg_i.settle)) begin
      phase_d = PH_TRIG;
      pcnt_d  = '0;
    end

    sensor_ext     = {3'b000, sensor_d};
    ctrl_o.trigger = phase_d == PH_TRIG;
    ctrl_o.sensor  = sensor_ext[SENSOR_OUT_W-1:0];

    unique case (phase_d)
      PH_SETTLE, PH_GAP: begin
        pcnt_d = pcnt_d + 1'b1;
      end
      PH_TRIG: begin
        pcnt_d = pcnt_d + 1'b1;
        if (pcnt_d >= PHASE_CNT_W'(cfg_i.trig)) begin
          phase_d = PH_WAIT1;
          pcnt_d  = '0;
        end
      end
      PH_WAIT1: begin
        if (echo_edge) begin
          phase_d = PH_WAIT2;
          pcnt_d  = '0;
          pulse_d = '0;
        end else if (pcnt_d >= PHASE_CNT_W'(cfg_i.timeout)) begin
          ctrl_o.done    = 1'b1;
          ctrl_o.timeout = 1'b1;
        end else begin
          pcnt_d = pcnt_d + 1'b1;
        end
      end
      PH_WAIT2: begin
        pulse_d = pulse_d + 1'b1;
        if (echo_edge) begin
          ctrl_o.done = 1'b1;
        end else if (pcnt_d >= PHASE_CNT_W'(cfg_i.timeout)) begin
          ctrl_o.done    = 1'b1;
          ctrl_o.timeout = 1'b1;
        end else begin
          pcnt_d = pcnt_d + 1'b1;
        end
      end
      default: begin
        phase_d = PH_SETTLE;
      end
    endcase

    // measurement finished: move to the next sensor or to the gap
    if (ctrl_o.done) begin
      pcnt_d = '0;
      if (sensor_d == LAST_SENSOR) begin
        ctrl_o.scan_end = 1'b1;
        phase_d         = PH_GAP;
      end else begin
        sensor_d = sensor_d + 1'b1;
        phase_d  = PH_SETTLE;
      end
    end
  end

  assign len_o = pulse_d;

  // sequencer state, advanced once per accepted tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_SETTLE;
      sensor_q    <= '0;
      pcnt_q      <= '0;
      pulse_q     <= '0;
      last_echo_q <= 1'b0;
    end else if (push_o) begin
      phase_q     <= phase_d;
      sensor_q    <= sensor_d;
      pcnt_q      <= pcnt_d;
      pulse_q     <= pulse_d;
      last_echo_q <= echo_level_i;
    end
  end

endmodule

// ===== rtl/msr_fifo.sv =====
// short queue between the front and back ends
`include "assert_macros.svh"

module msr_fifo import msr_pkg::*; #(
  parameter int DEPTH = FIFO_DEPTH_DEF,
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;

  assign full_o  = count_q == CNT_FULL;
  assign empty_o = count_q == '0;
  assign data_o  = mem_q[rd_ptr_q];

  // storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  `ASSERT_IMPLIES(a_no_overflow, clk_i, rst_ni, push_i, !full_o)
  `ASSERT_IMPLIES(a_no_underflow, clk_i, rst_ni, pop_i, !empty_o)

endmodule

// ===== rtl/msr_back.sv =====
// back end: range conversion with a serial divider and the output register
`include "assert_macros.svh"

module msr_back import msr_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  msr_back_cfg_t           cfg_i,
  input  logic                    empty_i,
  input  msr_ctrl_t               ctrl_i,
  input  logic [COUNT_BITS-1:0]   len_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic                    trigger_out_o,
  output logic [SENSOR_OUT_W-1:0] mux_select_o,
  output logic                    range_valid_o,
  output logic [SENSOR_OUT_W-1:0] range_sensor_o,
  output logic [CM_W-1:0]         range_cm_o,
  output logic                    no_echo_o,
  output logic                    stop_motors_o
);

  localparam int DIVD_W = COUNT_BITS - 1;
  localparam int STEP_W = $clog2(DIVD_W);

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_HOLD
  } back_state_e;

  back_state_e        state_q;
  logic [DIVD_W-1:0]  sr_q, sr_n;
  logic [TPC_W-1:0]   rem_q, rem_n;
  logic [STEP_W-1:0]  step_q;
  msr_ctrl_t          held_q;
  logic               near_q;
  logic               out_valid_q;

  msr_ctrl_t          out_ctrl_q;
  logic [CM_W-1:0]    out_cm_q;
  logic               out_stop_q;

  logic               out_free;
  logic               head_div;
  logic [CM_W-1:0]    direct_cm;
  logic [CM_W-1:0]    sat_cm;
  logic [TPC_W:0]     trial, diff;
  logic               ge;
  logic               load_en;
  msr_ctrl_t          load_ctrl;
  logic [CM_W-1:0]    load_cm;
  logic               near_t;

  // head classification and pop
  assign out_free  = !out_valid_q || out_ready_i;
  assign head_div  = ctrl_i.done && !ctrl_i.timeout && (cfg_i.tpc != '0);
  assign pop_o     = (state_q == B_IDLE) && !empty_i && (head_div || out_free);
  assign direct_cm = ctrl_i.timeout ? CM_NO_ECHO : (ctrl_i.done ? CM_SAT : '0);

  // one restoring division step per cycle
  always_comb begin
    trial = {rem_q, sr_q[DIVD_W-1]};
    diff  = trial - {1'b0, cfg_i.tpc};
    ge    = trial >= {1'b0, cfg_i.tpc};
    rem_n = ge ? diff[TPC_W-1:0] : trial[TPC_W-1:0];
    sr_n  = {sr_q[DIVD_W-2:0], ge};
  end

  assign sat_cm = (sr_q > DIVD_W'(CM_SAT)) ? CM_SAT : sr_q[CM_W-1:0];

  // result selection and near tracking
  always_comb begin
    load_en   = 1'b0;
    load_ctrl = ctrl_i;
    load_cm   = direct_cm;
    if (state_q == B_HOLD) begin
      load_en   = out_free;
      load_ctrl = held_q;
      load_cm   = sat_cm;
    end else if (state_q == B_IDLE) begin
      load_en = pop_o && !head_div;
    end
    near_t = near_q || (load_ctrl.done && (load_cm <= CM_W'(cfg_i.stop)));
  end

  // sequencer, divider and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      near_q      <= 1'b0;
      out_valid_q <= 1'b0;
      sr_q        <= '0;
      rem_q       <= '0;
      step_q      <= '0;
      held_q      <= '0;
      out_ctrl_q  <= '0;
      out_cm_q    <= '0;
      out_stop_q  <= 1'b0;
    end else begin
      if (load_en) begin
        out_valid_q <= 1'b1;
        out_ctrl_q  <= load_ctrl;
        out_cm_q    <= load_cm;
        out_stop_q  <= load_ctrl.done && load_ctrl.scan_end && near_t;
        near_q      <= (load_ctrl.done && load_ctrl.scan_end) ? 1'b0 : near_t;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        B_IDLE: begin
          if (pop_o && head_div) begin
            sr_q    <= len_i[COUNT_BITS-1:1];
            rem_q   <= '0;
            step_q  <= STEP_W'(DIVD_W - 1);
            held_q  <= ctrl_i;
            state_q <= B_DIV;
          end
        end
        B_DIV: begin
          sr_q  <= sr_n;
          rem_q <= rem_n;
          if (step_q == '0) begin
            state_q <= B_HOLD;
          end else begin
            step_q <= step_q - 1'b1;
          end
        end
        B_HOLD: begin
          if (out_free) begin
            state_q <= B_IDLE;
          end
        end
        default: begin
          state_q <= B_IDLE;
        end
      endcase
    end
  end

  // output ports
  assign out_valid_o    = out_valid_q;
  assign trigger_out_o  = out_ctrl_q.trigger;
  assign mux_select_o   = out_ctrl_q.sensor;
  assign range_valid_o  = out_ctrl_q.done;
  assign range_sensor_o = out_ctrl_q.done ? out_ctrl_q.sensor : '0;
  assign range_cm_o     = out_ctrl_q.done ? out_cm_q : '0;
  assign no_echo_o      = out_ctrl_q.done && out_ctrl_q.timeout;
  assign stop_motors_o  = out_stop_q;

  `ASSERT_IMPLIES(a_cm_in_range, clk_i, rst_ni, out_valid_o, range_cm_o <= CM_NO_ECHO)
  `ASSERT_IMPLIES(a_stop_with_range, clk_i, rst_ni, out_valid_o && stop_motors_o, range_valid_o)
  `ASSERT_IMPLIES(a_no_pop_busy, clk_i, rst_ni, state_q != B_IDLE, !pop_o)
  `ASSERT_NEXT(a_div_starts, clk_i, rst_ni, pop_o && head_div, state_q == B_DIV)

endmodule

// ===== rtl/multiplexed_sonar_ranger_top.sv =====
// Multiplexed sonar ranger: scans the sensors and reports ranges tick by tick.
// Input channel: one transaction per clock tick of the measured system,
// carrying the sampled echo level (in_valid_i / in_ready_o).
// Output channel: one transaction per input transaction, in order, carrying
// the trigger drive, mux select and, when a measurement finishes, the range,
// no-echo flag and the end-of-scan stop_motors pulse (out_valid_o / out_ready_i).
// Config: cfg_we_i writes cfg_data_i into register cfg_index_i at once; write
// only while the block is idle.
// Conversion: ticks that finish no echo measurement, time out or see a zero divisor
// pass from the queue straight into the output register; a tick that finishes an
// echo otherwise goes first through the serial divider that converts the pulse
// length into centimetres, one quotient bit a cycle. Throughput is one tick per
// cycle while the queue of FIFO_DEPTH entries absorbs the divider time and the
// receiver takes results; the back end takes no new tick while the divider is busy.
// Reset: registers return to their defaults, the scan restarts at sensor 0
// in the settle phase, queue and output register are emptied.
// Receiver stall: the output register holds its transaction, the queue
// fills, then in_ready_o drops until the receiver takes results again.
module multiplexed_sonar_ranger_top import msr_pkg::*; #(
  parameter int NUM_SENSORS = NUM_SENSORS_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF,
  parameter int FIFO_DEPTH  = FIFO_DEPTH_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    echo_level_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic                    trigger_out_o,
  output logic [SENSOR_OUT_W-1:0] mux_select_o,
  output logic                    range_valid_o,
  output logic [SENSOR_OUT_W-1:0] range_sensor_o,
  output logic [CM_W-1:0]         range_cm_o,
  output logic                    no_echo_o,
  output logic                    stop_motors_o
);

  localparam int CTRL_W = $bits(msr_ctrl_t);
  localparam int FIFO_W = CTRL_W + COUNT_BITS;

  msr_front_cfg_t        front_cfg_q;
  msr_back_cfg_t         back_cfg_q;

  logic                  push, pop, full, empty;
  msr_ctrl_t             push_ctrl, head_ctrl;
  logic [COUNT_BITS-1:0] push_len, head_len;
  logic [FIFO_W-1:0]     fifo_wdata, fifo_rdata;

  // configuration register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_cfg_q.settle  <= SETTLE_RST;
      front_cfg_q.trig    <= TRIG_RST;
      front_cfg_q.timeout <= TIMEOUT_RST;
      front_cfg_q.gap     <= GAP_RST;
      back_cfg_q.tpc      <= TPC_RST;
      back_cfg_q.stop     <= STOP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_SETTLE:  front_cfg_q.settle  <= cfg_data_i[SETTLE_W-1:0];
        REG_TRIG:    front_cfg_q.trig    <= cfg_data_i[TRIG_W-1:0];
        REG_TIMEOUT: front_cfg_q.timeout <= cfg_data_i[TIMEOUT_W-1:0];
        REG_TPC:     back_cfg_q.tpc      <= cfg_data_i[TPC_W-1:0];
        REG_STOP:    back_cfg_q.stop     <= cfg_data_i[STOP_W-1:0];
        REG_GAP:     front_cfg_q.gap     <= cfg_data_i[GAP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // tick sequencer
  msr_front #(
    .NUM_SENSORS (NUM_SENSORS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (front_cfg_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .echo_level_i (echo_level_i),
    .full_i       (full),
    .push_o       (push),
    .ctrl_o       (push_ctrl),
    .len_o        (push_len)
  );

  assign fifo_wdata = {push_ctrl, push_len};

  // decoupling queue
  msr_fifo #(
    .DEPTH (FIFO_DEPTH),
    .WIDTH (FIFO_W)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (fifo_wdata),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (fifo_rdata)
  );

  assign head_ctrl = fifo_rdata[FIFO_W-1:COUNT_BITS];
  assign head_len  = fifo_rdata[COUNT_BITS-1:0];

  // range conversion and output
  msr_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (back_cfg_q),
    .empty_i        (empty),
    .ctrl_i         (head_ctrl),
    .len_i          (head_len),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .trigger_out_o  (trigger_out_o),
    .mux_select_o   (mux_select_o),
    .range_valid_o  (range_valid_o),
    .range_sensor_o (range_sensor_o),
    .range_cm_o     (range_cm_o),
    .no_echo_o      (no_echo_o),
    .stop_motors_o  (stop_motors_o)
  );

endmodule

// ===== tb/sv/tb.sv =====
// self-checking testbench for the multiplexed sonar ranger, tick by tick against a local predictor
`timescale 1ns / 100ps

module tb;
  import msr_pkg::*;

  localparam int NUM_SENSORS      = NUM_SENSORS_DEF;
  localparam int COUNT_BITS       = COUNT_BITS_DEF;
  localparam int DRAIN_CYCLES     = COUNT_BITS + 16;
  localparam int CYCLE_LIMIT      = 400000;
  localparam int RANDOM_ITEMS     = 1150;
  localparam int MIN_MEASUREMENTS = 32;
  localparam int RANDOM_PHASE_LEN = 144;
  localparam int MAX_REPORTS      = 10;

  // unused register slots
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(7);

  // wait plan that never produces an edge
  localparam logic [PHASE_CNT_W-1:0] NO_EDGE = '1;

  typedef enum logic [2:0] {ST_SETTLE, ST_TRIG, ST_WAIT1, ST_WAIT2, ST_GAP} scan_phase_e;

  typedef struct {
    logic [SETTLE_W-1:0]  settle;
    logic [TRIG_W-1:0]    trig;
    logic [TIMEOUT_W-1:0] timeout;
    logic [TPC_W-1:0]     tpc;
    logic [STOP_W-1:0]    stop;
    logic [GAP_W-1:0]     gap;
  } ranger_cfg_t;

  typedef struct {
    scan_phase_e            phase;
    int unsigned            sensor;
    logic [PHASE_CNT_W-1:0] phase_cnt;
    logic [COUNT_BITS-1:0]  pulse_cnt;
    logic                   last_echo;
    logic                   near_seen;
  } scan_state_t;

  typedef struct packed {
    logic                    trigger_out;
    logic [SENSOR_OUT_W-1:0] mux_select;
    logic                    range_valid;
    logic [SENSOR_OUT_W-1:0] range_sensor;
    logic [CM_W-1:0]         range_cm;
    logic                    no_echo;
    logic                    stop_motors;
  } tick_result_t;

  typedef struct {
    logic echo;
    bit   hold_for_drain;
  } echo_tick_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]   cfg_data_i = '0;
  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  logic                    echo_level_i = 1'b0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic                    trigger_out_o;
  logic [SENSOR_OUT_W-1:0] mux_select_o;
  logic                    range_valid_o;
  logic [SENSOR_OUT_W-1:0] range_sensor_o;
  logic [CM_W-1:0]         range_cm_o;
  logic                    no_echo_o;
  logic                    stop_motors_o;

  ranger_cfg_t  range_cfg;
  scan_state_t  chk_state;
  scan_state_t  gen_state;
  tick_result_t expected_ticks[$];
  echo_tick_t   pending_ticks[$];

  logic [PHASE_CNT_W-1:0] wait_plan = NO_EDGE;
  bit          noisy_wait = 1'b0;
  bit          in_accepted = 1'b0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned items_queued = 0;
  int unsigned measurements = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  multiplexed_sonar_ranger_top #(
    .NUM_SENSORS(NUM_SENSORS),
    .COUNT_BITS (COUNT_BITS)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .echo_level_i  (echo_level_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .trigger_out_o (trigger_out_o),
    .mux_select_o  (mux_select_o),
    .range_valid_o (range_valid_o),
    .range_sensor_o(range_sensor_o),
    .range_cm_o    (range_cm_o),
    .no_echo_o     (no_echo_o),
    .stop_motors_o (stop_motors_o)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // one tick of the scanner: advances the state and returns the outputs of that tick
  function automatic void ranger_tick(inout scan_state_t s, input ranger_cfg_t c,
                                      input logic echo, output tick_result_t r);
    logic        toggled;
    logic        fin;
    logic        miss;
    logic        stop;
    logic [CM_W-1:0] cm;
    int unsigned which;
    int unsigned quot;
    toggled = echo != s.last_echo;
    fin = 1'b0;
    miss = 1'b0;
    stop = 1'b0;
    cm = '0;
    r = '0;

    // phase ends are checked before the tick is spent
    if (s.phase == ST_GAP && s.phase_cnt >= c.gap) begin
      s.phase = ST_SETTLE;
      s.sensor = 0;
      s.phase_cnt = '0;
    end
    if (s.phase == ST_SETTLE && s.phase_cnt >= c.settle) begin
      s.phase = ST_TRIG;
      s.phase_cnt = '0;
    end

    r.trigger_out = (s.phase == ST_TRIG);
    r.mux_select = SENSOR_OUT_W'(s.sensor);
    which = s.sensor;

    case (s.phase)
      ST_SETTLE, ST_GAP: begin
        s.phase_cnt = s.phase_cnt + 1'b1;
      end
      ST_TRIG: begin
        // a zero length still drives the trigger for one tick
        s.phase_cnt = s.phase_cnt + 1'b1;
        if (s.phase_cnt >= c.trig) begin
          s.phase = ST_WAIT1;
          s.phase_cnt = '0;
        end
      end
      ST_WAIT1: begin
        if (toggled) begin
          s.phase = ST_WAIT2;
          s.phase_cnt = '0;
          s.pulse_cnt = '0;
        end else if (s.phase_cnt >= c.timeout) begin
          fin = 1'b1;
          miss = 1'b1;
          cm = CM_NO_ECHO;
        end else begin
          s.phase_cnt = s.phase_cnt + 1'b1;
        end
      end
      default: begin
        s.pulse_cnt = s.pulse_cnt + 1'b1;
        if (toggled) begin
          fin = 1'b1;
          // zero divisor reports the saturated range
          if (c.tpc == '0) begin
            cm = CM_SAT;
          end else begin
            quot = 32'(s.pulse_cnt >> 1) / 32'(c.tpc);
            cm = (quot > 998) ? CM_SAT : CM_W'(quot);
          end
        end else if (s.phase_cnt >= c.timeout) begin
          fin = 1'b1;
          miss = 1'b1;
          cm = CM_NO_ECHO;
        end else begin
          s.phase_cnt = s.phase_cnt + 1'b1;
        end
      end
    endcase

    // sensor done: advance or close the scan
    if (fin) begin
      if (cm <= c.stop) s.near_seen = 1'b1;
      s.phase_cnt = '0;
      if (s.sensor + 1 >= NUM_SENSORS) begin
        stop = s.near_seen;
        s.near_seen = 1'b0;
        s.phase = ST_GAP;
      end else begin
        s.sensor = s.sensor + 1;
        s.phase = ST_SETTLE;
      end
    end

    s.last_echo = echo;

    r.range_valid = fin;
    r.range_sensor = fin ? SENSOR_OUT_W'(which) : '0;
    r.range_cm = fin ? cm : '0;
    r.no_echo = miss;
    r.stop_motors = stop;
  endfunction

  // tick count at which the echo line toggles during an edge wait
  function automatic logic [PHASE_CNT_W-1:0] pick_plan(logic [TIMEOUT_W-1:0] timeout,
                                                      bit allow_miss);
    int unsigned cap;
    int unsigned roll;
    cap = (timeout > 200) ? 200 : timeout;
    roll = $urandom_range(99);
    if (allow_miss && roll < 10) return NO_EDGE;
    if (roll < 25) return PHASE_CNT_W'(cap);
    if (roll < 35) return '0;
    return PHASE_CNT_W'($urandom_range(cap, 0));
  endfunction

  // build echo ticks that follow the scanner's phases, with some noise
  task automatic queue_ticks(int unsigned count, int hold_at);
    scan_phase_e  was;
    tick_result_t r;
    logic         lvl;
    echo_tick_t   item;
    for (int k = 0; k < count; k++) begin
      case (gen_state.phase)
        ST_WAIT1, ST_WAIT2: begin
          if (noisy_wait) lvl = 1'($urandom_range(1));
          else lvl = gen_state.last_echo ^ (gen_state.phase_cnt == wait_plan);
        end
        default: begin
          lvl = ($urandom_range(7) == 0) ? ~gen_state.last_echo : gen_state.last_echo;
        end
      endcase
      item.echo = lvl;
      item.hold_for_drain = (k == hold_at);
      pending_ticks.push_back(item);
      was = gen_state.phase;
      ranger_tick(gen_state, range_cfg, lvl, r);
      items_queued++;
      if (r.range_valid) measurements++;
      if (gen_state.phase != was && gen_state.phase == ST_WAIT1) begin
        noisy_wait = ($urandom_range(99) < 8);
        wait_plan = pick_plan(range_cfg.timeout, 1'b1);
      end else if (gen_state.phase != was && gen_state.phase == ST_WAIT2) begin
        wait_plan = pick_plan(range_cfg.timeout, 1'b1);
      end
    end
  endtask

  // one register write, also applied to the local copy
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    case (idx)
      REG_SETTLE:  range_cfg.settle = val[SETTLE_W-1:0];
      REG_TRIG:    range_cfg.trig = val[TRIG_W-1:0];
      REG_TIMEOUT: range_cfg.timeout = val[TIMEOUT_W-1:0];
      REG_TPC:     range_cfg.tpc = val[TPC_W-1:0];
      REG_STOP:    range_cfg.stop = val[STOP_W-1:0];
      REG_GAP:     range_cfg.gap = val[GAP_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_config(logic [SETTLE_W-1:0] settle, logic [TRIG_W-1:0] trig,
                             logic [TIMEOUT_W-1:0] timeout, logic [TPC_W-1:0] tpc,
                             logic [STOP_W-1:0] stop, logic [GAP_W-1:0] gap);
    write_reg(REG_SETTLE, CFG_DATA_W'(settle));
    write_reg(REG_TRIG, CFG_DATA_W'(trig));
    write_reg(REG_TIMEOUT, CFG_DATA_W'(timeout));
    write_reg(REG_TPC, CFG_DATA_W'(tpc));
    write_reg(REG_STOP, CFG_DATA_W'(stop));
    write_reg(REG_GAP, CFG_DATA_W'(gap));
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_idling(int unsigned mode);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
      default: begin send_idle_pct = 35; recv_stall_pct = 35; end
    endcase
  endtask

  // wait until every tick is sent and answered, then let the divider drain
  task automatic settle_down();
    do @(posedge clk_i);
    while (pending_ticks.size() > 0 || in_valid_i || expected_ticks.size() > 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic flag_mismatch(string what, tick_result_t want, tick_result_t seen);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("%0t %s: expected trig=%0b mux=%0d valid=%0b sensor=%0d cm=%0d noecho=%0b stop=%0b",
               $time, what, want.trigger_out, want.mux_select, want.range_valid,
               want.range_sensor, want.range_cm, want.no_echo, want.stop_motors);
      $display("    got trig=%0b mux=%0d valid=%0b sensor=%0d cm=%0d noecho=%0b stop=%0b",
               seen.trigger_out, seen.mux_select, seen.range_valid, seen.range_sensor,
               seen.range_cm, seen.no_echo, seen.stop_motors);
    end
  endtask

  // driver: new transaction at the falling edge once the previous one is taken
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_accepted) begin
        in_accepted = 1'b0;
        if (pending_ticks.size() > 0 &&
            !(pending_ticks[0].hold_for_drain && expected_ticks.size() > 0) &&
            $urandom_range(99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          echo_level_i <= pending_ticks[0].echo;
          void'(pending_ticks.pop_front());
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor: predict on accepted input, check accepted output
  always @(posedge clk_i) begin : monitor
    tick_result_t want;
    tick_result_t seen;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        ranger_tick(chk_state, range_cfg, echo_level_i, want);
        expected_ticks.push_back(want);
        in_accepted = 1'b1;
      end
      if (out_valid_o && out_ready_i) begin
        seen = '{trigger_out_o, mux_select_o, range_valid_o, range_sensor_o,
                 range_cm_o, no_echo_o, stop_motors_o};
        if (expected_ticks.size() == 0) begin
          flag_mismatch("result with nothing pending", '0, seen);
        end else begin
          want = expected_ticks.pop_front();
          if (seen !== want) flag_mismatch("mismatch", want, seen);
        end
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // stimulus sequence
  initial begin
    int unsigned phase_no;
    int          hold_at;
    range_cfg = '{SETTLE_RST, TRIG_RST, TIMEOUT_RST, TPC_RST, STOP_RST, GAP_RST};
    chk_state = '{ST_SETTLE, 0, '0, '0, 1'b0, 1'b0};
    gen_state = chk_state;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    // zero settle, trigger, timeout, divisor and gap; every range counts as near
    set_idling(0);
    write_reg(REG_SPARE_A, CFG_DATA_W'($urandom));
    write_reg(REG_SPARE_B, CFG_DATA_W'($urandom));
    load_config('0, '0, '0, '0, STOP_W'(1023), '0);
    queue_ticks(30, -1);
    settle_down();

    // upper extremes of every register but the stop threshold, which is zero
    set_idling(3);
    load_config('1, '1, '1, '1, '0, '1);
    queue_ticks(40, -1);
    settle_down();

    // random short timings, idling pattern rotating per phase
    phase_no = 0;
    while ((items_queued < RANDOM_ITEMS || measurements < MIN_MEASUREMENTS) &&
           phase_no < 40) begin
      set_idling(phase_no % 4);
      load_config(SETTLE_W'($urandom_range(8)), TRIG_W'($urandom_range(5, 1)),
                  TIMEOUT_W'($urandom_range(48)), TPC_W'($urandom_range(6, 1)),
                  ($urandom_range(7) == 0) ? STOP_W'(999) : STOP_W'($urandom_range(16)),
                  GAP_W'($urandom_range(10)));
      hold_at = (phase_no == 2) ? RANDOM_PHASE_LEN / 2 : -1;
      queue_ticks(RANDOM_PHASE_LEN, hold_at);
      settle_down();
      phase_no++;
    end

    if (mismatches == 0 && expected_ticks.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
